>>> rtl/core/rss_pkg.sv
// shared types and sizing constants for the rolling-sum substring search
// no dependencies; every other file refers to this package by scoped names
`default_nettype none

package rss_pkg;

	localparam int unsigned PatternMax   = 16;
	localparam int unsigned PositionBits = 16;
	localparam int unsigned PatLenBits   = $clog2(PatternMax + 1);
	localparam int unsigned WinIdxBits   = $clog2(PatternMax);
	localparam int unsigned SumBits      = 8 + $clog2(PatternMax);
	localparam int unsigned CountBits    = PositionBits + 1;
	localparam int unsigned CmdqDepth    = 4;
	localparam int unsigned CmdqPtrBits  = $clog2(CmdqDepth);
	localparam int unsigned CmdqCntBits  = $clog2(CmdqDepth + 1);

	localparam logic [CountBits-1:0]  PosLimit  = {1'b1, {PositionBits{1'b0}}};
	localparam logic [PatLenBits-1:0] PatMaxLen = PatLenBits'(PatternMax);

	typedef enum logic [0:0] {
		CMD_PATTERN = 1'b0,
		CMD_TEXT    = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data_byte;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic                    found;
		logic [PositionBits-1:0] position;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/rss_front.sv
// front end: takes input beats, classifies them and holds them in one stage
// until the command queue has room; uses rss_pkg
`default_nettype none

module rss_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic          op,
	input  wire logic [7:0]    data_byte,
	input  wire logic          last,
	output logic               q_push,
	input  wire logic          q_full,
	output rss_pkg::cmd_t      q_cmd
);

	logic          valid_s1;
	rss_pkg::cmd_t cmd_s1;
	logic          accept;

	assign q_push = valid_s1 && !q_full;
	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.kind      <= op ? rss_pkg::CMD_TEXT : rss_pkg::CMD_PATTERN;
			cmd_s1.data_byte <= data_byte;
			cmd_s1.last      <= last;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rss_cmdq.sv
// short command queue between the front end and the search engine
// depth from rss_pkg::CmdqDepth; uses rss_pkg
`default_nettype none

module rss_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire rss_pkg::cmd_t wr_cmd,
	output logic               full,
	input  wire logic          rd_en,
	output rss_pkg::cmd_t      rd_cmd,
	output logic               empty
);

	rss_pkg::cmd_t                      mem_q [rss_pkg::CmdqDepth];
	logic [rss_pkg::CmdqPtrBits-1:0]    wr_ptr_q;
	logic [rss_pkg::CmdqPtrBits-1:0]    rd_ptr_q;
	logic [rss_pkg::CmdqCntBits-1:0]    count_q;
	logic                               do_wr;
	logic                               do_rd;

	assign full   = count_q == rss_pkg::CmdqCntBits'(rss_pkg::CmdqDepth);
	assign empty  = count_q == '0;
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rss_back.sv
// search engine: pattern store, text window with running sum, side-by-side
// byte compare and the result register; uses rss_pkg
`default_nettype none

module rss_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rss_pkg::cmd_t cmd,
	input  wire logic          cmd_empty,
	output logic               cmd_pop,
	output logic               empty,
	input  wire logic          pop,
	output rss_pkg::result_t   result
);

	localparam int unsigned Pm = rss_pkg::PatternMax;

	// pattern is kept right-aligned so cell i always lines up with window byte i
	logic [7:0]                       pat_q [Pm];
	logic [rss_pkg::PatLenBits-1:0]   pat_len_q;
	logic [rss_pkg::SumBits-1:0]      pat_sum_q;
	logic                             pat_closed_q;
	logic [7:0]                       win_q [Pm];
	logic [rss_pkg::SumBits-1:0]      win_sum_q;
	logic [rss_pkg::CountBits-1:0]    text_cnt_q;
	logic                             match_seen_q;
	logic                             res_valid_q;
	rss_pkg::result_t                 res_q;

	logic                             res_pop;
	logic                             is_text;
	logic                             k_nz;
	logic                             active;
	logic [rss_pkg::WinIdxBits-1:0]   drop_idx;
	logic [7:0]                       drop_byte;
	logic [7:0]                       win_nx [Pm];
	logic [rss_pkg::SumBits-1:0]      sum_nx;
	logic [rss_pkg::CountBits-1:0]    cnt_nx;
	logic [Pm-1:0]                    cell_en;
	logic [Pm-1:0]                    cell_ok;
	logic                             cnt_ok;
	logic                             hit;
	logic                             miss_end;
	logic [rss_pkg::PatLenBits-1:0]   base_len;
	logic [rss_pkg::SumBits-1:0]      base_sum;
	logic                             pat_room;

	assign empty   = !res_valid_q;
	assign result  = res_q;
	assign res_pop = pop && res_valid_q;
	assign cmd_pop = !cmd_empty && (!res_valid_q || res_pop);

	assign is_text   = cmd.kind == rss_pkg::CMD_TEXT;
	assign k_nz      = pat_len_q != '0;
	assign active    = !match_seen_q && (text_cnt_q < rss_pkg::PosLimit);
	assign drop_idx  = rss_pkg::WinIdxBits'(rss_pkg::PatMaxLen - pat_len_q);
	assign drop_byte = win_q[drop_idx];
	assign sum_nx    = win_sum_q - rss_pkg::SumBits'(drop_byte)
			+ rss_pkg::SumBits'(cmd.data_byte);
	assign cnt_nx    = text_cnt_q + 1'b1;
	assign cnt_ok    = cnt_nx >= rss_pkg::CountBits'(pat_len_q);

	for (genvar i = 0; i < Pm; i++) begin : g_cell
		if (i == Pm - 1) begin : g_head
			assign win_nx[i] = cmd.data_byte;
		end else begin : g_body
			assign win_nx[i] = win_q[i+1];
		end
		// cell i is inside the k-byte window when i >= PatternMax - k
		assign cell_en[i] = pat_len_q > rss_pkg::PatLenBits'(Pm - 1 - i);
		assign cell_ok[i] = !cell_en[i] || (win_nx[i] == pat_q[i]);
	end

	assign hit = is_text && active && k_nz && cnt_ok && (sum_nx == pat_sum_q) && (&cell_ok);
	assign miss_end = is_text && cmd.last && !match_seen_q && !hit;

	assign base_len = pat_closed_q ? '0 : pat_len_q;
	assign base_sum = pat_closed_q ? '0 : pat_sum_q;
	assign pat_room = base_len < rss_pkg::PatMaxLen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q    <= '0;
			pat_sum_q    <= '0;
			pat_closed_q <= 1'b1;
			win_sum_q    <= '0;
			text_cnt_q   <= '0;
			match_seen_q <= 1'b0;
			for (int i = 0; i < Pm; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd_pop) begin
			unique case (cmd.kind)
				rss_pkg::CMD_PATTERN: begin
					pat_len_q    <= pat_room ? base_len + 1'b1 : base_len;
					pat_sum_q    <= pat_room ? base_sum + rss_pkg::SumBits'(cmd.data_byte)
							: base_sum;
					pat_closed_q <= cmd.last;
					win_sum_q    <= '0;
					text_cnt_q   <= '0;
					match_seen_q <= 1'b0;
					for (int i = 0; i < Pm; i++) begin
						win_q[i] <= '0;
					end
				end
				rss_pkg::CMD_TEXT: begin
					pat_closed_q <= 1'b1;
					if (cmd.last) begin
						win_sum_q    <= '0;
						text_cnt_q   <= '0;
						match_seen_q <= 1'b0;
						for (int i = 0; i < Pm; i++) begin
							win_q[i] <= '0;
						end
					end else if (active) begin
						if (k_nz) begin
							win_sum_q <= sum_nx;
							for (int i = 0; i < Pm; i++) begin
								win_q[i] <= win_nx[i];
							end
						end
						text_cnt_q <= cnt_nx;
						if (hit) begin
							match_seen_q <= 1'b1;
						end
					end
				end
				default: begin
					pat_closed_q <= pat_closed_q;
				end
			endcase
		end
	end

	// pattern bytes shift in from the top end
	always_ff @(posedge clk) begin
		if (cmd_pop && !is_text && pat_room) begin
			for (int i = 0; i < Pm - 1; i++) begin
				pat_q[i] <= pat_q[i+1];
			end
			pat_q[Pm-1] <= cmd.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else priority if (cmd_pop && (hit || miss_end)) begin
			res_valid_q <= 1'b1;
		end else if (res_pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && (hit || miss_end)) begin
			res_q.found    <= hit;
			res_q.position <= hit ? rss_pkg::PositionBits'(cnt_nx
					- rss_pkg::CountBits'(pat_len_q)) : '0;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pat_len_q <= rss_pkg::PatMaxLen)
		else $error("pattern length beyond store depth");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		text_cnt_q <= rss_pkg::PosLimit)
		else $error("text counter ran past its limit");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (!res_valid_q || res_pop))
		else $error("command taken while result slot occupied");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && hit) |-> !match_seen_q)
		else $error("second match reported in one search");

	a_hit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && hit && !cmd.last) |=> match_seen_q)
		else $error("match not recorded");

endmodule

`default_nettype wire

>>> rtl/core/rolling_sum_substring_search_top.sv
// top level of the rolling-sum substring search: front end, command queue
// and search engine; uses rss_pkg, rss_front, rss_cmdq and rss_back
`default_nettype none

// Load a pattern of up to 16 bytes with op=0 beats (last closes it; each
// pattern beat clears any search in progress), then stream text with op=1
// beats. The block answers once per text: found=1 with the start position of
// the first match, or found=0 on the last text byte when nothing matched.
// One byte is taken per clock in steady state: the window shift, running sum
// and the 16 byte compares all happen together when the search engine takes
// a byte. The beat that causes a result is loaded into the front stage, then
// written into the four-entry command queue, and its result is then written
// into the result register, where it becomes visible; only a result left
// waiting on the output stalls intake, once the queue fills.

module rolling_sum_substring_search_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              op,
	input  wire logic [7:0]                        data_byte,
	input  wire logic                              last,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic                                   found,
	output logic [rss_pkg::PositionBits-1:0]       position
);

	logic             q_push;
	logic             q_full;
	rss_pkg::cmd_t    q_in;
	rss_pkg::cmd_t    q_out;
	logic             q_empty;
	logic             q_pop;
	rss_pkg::result_t res;

	rss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op        (op),
		.data_byte (data_byte),
		.last      (last),
		.q_push    (q_push),
		.q_full    (q_full),
		.q_cmd     (q_in)
	);

	rss_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_cmd (q_in),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_cmd (q_out),
		.empty  (q_empty)
	);

	rss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_out),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (res)
	);

	assign found    = res.found;
	assign position = res.position;

endmodule

`default_nettype wire
